@@ sv/lplc_pkg.sv @@
// Package for the lift PID controller: field widths, opcodes, register
// indexes, reset values and the stage flag struct.
// No dependencies.
package lplc_pkg;

   localparam int UNLOCK_TICKS_DEF = 25;

   localparam int OPCODE_W   = 3;
   localparam int POS_W      = 24;
   localparam int COUNT_W    = 23;
   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 32;
   localparam int SUM_W      = 48;
   localparam int ERR_W      = 25;
   localparam int DERIV_W    = 26;
   localparam int TIMER_W    = 5;
   localparam int VALVE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // products saturate at +-2^PROD_LIMIT_LOG2
   localparam int PROD_LIMIT_LOG2 = 60;
   // Q8.24 * error -> Q1.15 output
   localparam int OUT_SHIFT = 9;
   localparam int AT_TARGET_BAND = 500;

   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_TICK          = 3'd0;
   localparam opcode_type OP_TARGET_TOP    = 3'd1;
   localparam opcode_type OP_TARGET_ZERO   = 3'd2;
   localparam opcode_type OP_TARGET_BUDDY  = 3'd3;
   localparam opcode_type OP_LOOP_ON       = 3'd4;
   localparam opcode_type OP_LOOP_OFF      = 3'd5;
   localparam opcode_type OP_LOCK          = 3'd6;
   localparam opcode_type OP_RELEASE       = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CEILING  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_POSITION   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BUDDY_POSITION = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HOMED_AT_START = 3'd7;

   localparam logic [VALVE_W-1:0] VALVE_IDLE    = 2'd0;
   localparam logic [VALVE_W-1:0] VALVE_RELEASE = 2'd1;
   localparam logic [VALVE_W-1:0] VALVE_LOCK    = 2'd2;

   localparam logic signed [GAIN_W-1:0]  GAIN_P_RESET        = -32'sd13422;
   localparam logic signed [GAIN_W-1:0]  GAIN_I_RESET        = 32'sd0;
   localparam logic signed [GAIN_W-1:0]  GAIN_D_RESET        = 32'sd0;
   localparam logic signed [SPEED_W-1:0] SPEED_CEILING_RESET = 16'sd26214;
   localparam logic signed [SPEED_W-1:0] SPEED_FLOOR_RESET   = -16'sd14746;
   localparam logic [COUNT_W-1:0]        TOP_POSITION_RESET  = 23'd0;
   localparam logic [COUNT_W-1:0]        BUDDY_POSITION_RESET = 23'd3634;
   localparam logic                      HOMED_RESET         = 1'b1;

   // per-item control bits carried down the pipeline
   typedef struct packed {
      logic               tick;
      logic               loop_on;
      logic               locked;
      logic               low_hit;
      logic               up_hit;
      logic [VALVE_W-1:0] valve;
   } flags_type;

endpackage

@@ sv/limited_pid_lift_controller.sv @@
// Lift position PID with output clamp, limit/ratchet gating and homing.
// Depends on lplc_pkg.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | opcode, raw position, limit switches
//  rsp     | out       | rsp_valid / rsp_ready | motor command, valve, lock, loop, on-target
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready holds; from accept to rsp_valid the steps are:
// state update, gain multipliers, integral product merge and saturation, then
// sum, clamp and gating into the result register.
// Empty stages close up, so req_ready drops only when all four stages hold items
// and the result is not taken. Synchronous active-high reset clears control state.
module limited_pid_lift_controller #(
   parameter int UNLOCK_TICKS = lplc_pkg::UNLOCK_TICKS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  lplc_pkg::opcode_type                    req_opcode,
   input  logic signed [lplc_pkg::POS_W-1:0]       req_raw_position,
   input  logic                                    req_lower_limit_pressed,
   input  logic                                    req_upper_limit_pressed,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [lplc_pkg::SPEED_W-1:0]     rsp_motor_command,
   output logic [lplc_pkg::VALVE_W-1:0]            rsp_solenoid_state,
   output logic                                    rsp_ratchet_locked,
   output logic                                    rsp_loop_enabled,
   output logic                                    rsp_on_target,
   input  logic                                    csr_we,
   input  logic [lplc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [lplc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import lplc_pkg::*;

   localparam int PI_LO_W  = GAIN_W + 33;
   localparam int PI_HI_W  = GAIN_W + (SUM_W - 32);
   localparam int PP_W     = GAIN_W + ERR_W;
   localparam int PD_W     = GAIN_W + DERIV_W;
   localparam int PI_FULL_W = SUM_W + GAIN_W;
   localparam int PI_SAT_W = PROD_LIMIT_LOG2 + 2;
   localparam int PPD_W    = PD_W + 1;
   localparam int TOTAL_W  = PI_SAT_W + 1;
   localparam int SHIFT_W  = TOTAL_W - OUT_SHIFT;

   localparam logic signed [PI_FULL_W-1:0] PROD_MAX = PI_FULL_W'(1) <<< PROD_LIMIT_LOG2;
   localparam logic signed [PI_FULL_W-1:0] PROD_MIN = -PROD_MAX;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [POS_W:0] BAND_HI = (POS_W+1)'(AT_TARGET_BAND);
   localparam logic signed [POS_W:0] BAND_LO = -BAND_HI;
   localparam logic [TIMER_W-1:0] UNLOCK_COUNT = TIMER_W'(UNLOCK_TICKS);
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

   // configuration registers
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [SPEED_W-1:0] speed_ceiling_ff, speed_floor_ff;
   logic [COUNT_W-1:0]        top_position_ff, buddy_position_ff;
   logic                      homed_ff;

   // controller state
   logic signed [POS_W-1:0]   target_ff, target_in;
   logic [POS_W-1:0]          offset_ff, offset_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic                      loop_on_ff, loop_on_in;
   logic                      lock_ff, lock_in;
   logic [TIMER_W-1:0]        timer_ff, timer_in;
   logic                      running_ff, running_in;
   logic [VALVE_W-1:0]        valve_ff, valve_in;
   logic signed [SPEED_W-1:0] motor_hold_ff;

   // accept-stage logic
   logic                      accept;
   logic signed [POS_W-1:0]   cur_pos, pos1, pos_after;
   logic signed [POS_W-1:0]   tgt1, tgt2, top_s;
   logic                      low_home, up_home;
   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W:0]     sum_full;
   logic signed [SUM_W-1:0]   sum_sat;
   logic signed [DERIV_W-1:0] deriv;
   flags_type                 flags_in;

   // stage 1
   logic                      s1_v_ff;
   flags_type                 s1_flags_ff;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [SUM_W-1:0]   s1_sum_ff;
   logic signed [DERIV_W-1:0] s1_deriv_ff;
   logic signed [POS_W-1:0]   s1_pos_ff, s1_target_ff;

   // stage 2
   logic                      s2_v_ff;
   flags_type                 s2_flags_ff;
   logic signed [PP_W-1:0]    s2_pp_ff, pp;
   logic signed [PD_W-1:0]    s2_pd_ff, pd;
   logic signed [PI_LO_W-1:0] s2_pi_lo_ff, pi_lo;
   logic signed [PI_HI_W-1:0] s2_pi_hi_ff, pi_hi;
   logic                      s2_on_ff, on_target;
   logic signed [POS_W:0]     pos_diff;

   // stage 3
   logic                        s3_v_ff;
   flags_type                   s3_flags_ff;
   logic signed [PI_SAT_W-1:0]  s3_pi_ff, pi_sat;
   logic signed [PPD_W-1:0]     s3_ppd_ff, ppd;
   logic                        s3_on_ff;
   logic signed [PI_FULL_W-1:0] pi_full;

   // result stage
   logic                      rsp_valid_ff;
   logic signed [SPEED_W-1:0] rsp_motor_ff, rsp_motor_in;
   logic [VALVE_W-1:0]        rsp_valve_ff;
   logic                      rsp_lock_ff, rsp_loop_ff, rsp_on_ff;
   logic signed [TOTAL_W-1:0] total;
   logic signed [SHIFT_W-1:0] shifted, ceil_ext, floor_ext, clamp1, clamp2;
   logic signed [SPEED_W-1:0] speed, cmd;

   logic out_free, en3, en2, en1;

   // stage enables: a stage loads when empty or when its item moves on
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign en3       = !s3_v_ff || out_free;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_ready = en1;
   assign accept    = req_valid && en1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= GAIN_P_RESET;
         gain_i_ff         <= GAIN_I_RESET;
         gain_d_ff         <= GAIN_D_RESET;
         speed_ceiling_ff  <= SPEED_CEILING_RESET;
         speed_floor_ff    <= SPEED_FLOOR_RESET;
         top_position_ff   <= TOP_POSITION_RESET;
         buddy_position_ff <= BUDDY_POSITION_RESET;
         homed_ff          <= HOMED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_P:         gain_p_ff         <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:         gain_i_ff         <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:         gain_d_ff         <= csr_wdata[GAIN_W-1:0];
            REG_SPEED_CEILING:  speed_ceiling_ff  <= csr_wdata[SPEED_W-1:0];
            REG_SPEED_FLOOR:    speed_floor_ff    <= csr_wdata[SPEED_W-1:0];
            REG_TOP_POSITION:   top_position_ff   <= csr_wdata[COUNT_W-1:0];
            REG_BUDDY_POSITION: buddy_position_ff <= csr_wdata[COUNT_W-1:0];
            REG_HOMED_AT_START: homed_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // accept stage: homing, error, integral and command decode
   always_comb begin
      cur_pos  = req_raw_position - $signed(offset_ff);
      top_s    = $signed({1'b0, top_position_ff});
      low_home = req_lower_limit_pressed && (target_ff < cur_pos);
      tgt1     = low_home ? '0 : target_ff;
      pos1     = low_home ? '0 : cur_pos;
      up_home  = req_upper_limit_pressed && (tgt1 > pos1);
      tgt2     = up_home ? top_s : tgt1;

      err      = ERR_W'(cur_pos) - ERR_W'(tgt2);
      sum_full = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(err);
      if (sum_full[SUM_W] != sum_full[SUM_W-1]) begin
         sum_sat = sum_full[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_full[SUM_W-1:0];
      end
      deriv = DERIV_W'(err) - DERIV_W'(prev_err_ff);

      target_in   = target_ff;
      offset_in   = offset_ff;
      sum_in      = sum_ff;
      prev_err_in = prev_err_ff;
      loop_on_in  = loop_on_ff;
      lock_in     = lock_ff;
      timer_in    = timer_ff;
      running_in  = running_ff;
      valve_in    = valve_ff;
      pos_after   = cur_pos;

      case (req_opcode)
         OP_TICK: begin
            if (running_ff) begin
               if (timer_ff != '1) timer_in = timer_ff + 1'b1;
               if (timer_in >= UNLOCK_COUNT) lock_in = 1'b0;
            end
            if (up_home) begin
               offset_in = req_raw_position - top_s;
            end else if (low_home) begin
               offset_in = req_raw_position;
            end
            target_in   = tgt2;
            pos_after   = up_home ? top_s : pos1;
            sum_in      = sum_sat;
            prev_err_in = err;
         end
         OP_TARGET_TOP:  target_in = top_s;
         OP_TARGET_ZERO: target_in = '0;
         OP_TARGET_BUDDY: begin
            if (ERR_W'(cur_pos) > $signed({2'b00, buddy_position_ff}))
               target_in = $signed({1'b0, buddy_position_ff});
         end
         OP_LOOP_ON:  loop_on_in = 1'b1;
         OP_LOOP_OFF: loop_on_in = 1'b0;
         OP_LOCK: begin
            running_in = 1'b0;
            timer_in   = '0;
            lock_in    = 1'b1;
            valve_in   = VALVE_LOCK;
         end
         default: begin
            timer_in   = '0;
            running_in = 1'b1;
            valve_in   = VALVE_RELEASE;
         end
      endcase

      flags_in.tick    = (req_opcode == OP_TICK);
      flags_in.loop_on = loop_on_in;
      flags_in.locked  = lock_in;
      flags_in.low_hit = req_lower_limit_pressed;
      flags_in.up_hit  = req_upper_limit_pressed;
      flags_in.valve   = valve_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         offset_ff   <= '0;
         sum_ff      <= '0;
         prev_err_ff <= '0;
         loop_on_ff  <= 1'b0;
         lock_ff     <= 1'b0;
         timer_ff    <= '0;
         running_ff  <= 1'b0;
         valve_ff    <= VALVE_IDLE;
      end else if (accept) begin
         target_ff   <= target_in;
         offset_ff   <= offset_in;
         sum_ff      <= sum_in;
         prev_err_ff <= prev_err_in;
         loop_on_ff  <= loop_on_in;
         lock_ff     <= lock_in;
         timer_ff    <= timer_in;
         running_ff  <= running_in;
         valve_ff    <= valve_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_flags_ff  <= flags_in;
         s1_err_ff    <= err;
         s1_sum_ff    <= sum_sat;
         s1_deriv_ff  <= deriv;
         s1_pos_ff    <= pos_after;
         s1_target_ff <= target_in;
      end
   end

   // stage 2: gain products; the 48-bit integral is split into two halves
   always_comb begin
      pp       = s1_err_ff * gain_p_ff;
      pd       = s1_deriv_ff * gain_d_ff;
      pi_lo    = $signed({1'b0, s1_sum_ff[31:0]}) * gain_i_ff;
      pi_hi    = $signed(s1_sum_ff[SUM_W-1:32]) * gain_i_ff;
      pos_diff = (POS_W+1)'(s1_pos_ff) - (POS_W+1)'(s1_target_ff);
      on_target = (pos_diff < BAND_HI) && (pos_diff > BAND_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_flags_ff <= s1_flags_ff;
         s2_pp_ff    <= pp;
         s2_pd_ff    <= pd;
         s2_pi_lo_ff <= pi_lo;
         s2_pi_hi_ff <= pi_hi;
         s2_on_ff    <= on_target;
      end
   end

   // stage 3: merge integral halves and saturate; add P and D terms
   always_comb begin
      pi_full = {s2_pi_hi_ff, 32'd0}
              + {{(PI_FULL_W-PI_LO_W){s2_pi_lo_ff[PI_LO_W-1]}}, s2_pi_lo_ff};
      if (pi_full > PROD_MAX) begin
         pi_sat = PI_SAT_W'(PROD_MAX);
      end else if (pi_full < PROD_MIN) begin
         pi_sat = PI_SAT_W'(PROD_MIN);
      end else begin
         pi_sat = pi_full[PI_SAT_W-1:0];
      end
      ppd = PPD_W'(s2_pp_ff) + PPD_W'(s2_pd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_flags_ff <= s2_flags_ff;
         s3_pi_ff    <= pi_sat;
         s3_ppd_ff   <= ppd;
         s3_on_ff    <= s2_on_ff;
      end
   end

   // result stage: scale to Q1.15, clamp, gate and invert
   always_comb begin
      total     = TOTAL_W'(s3_pi_ff) + TOTAL_W'(s3_ppd_ff);
      shifted   = total[TOTAL_W-1:OUT_SHIFT];
      ceil_ext  = SHIFT_W'(speed_ceiling_ff);
      floor_ext = SHIFT_W'(speed_floor_ff);
      clamp1    = (shifted > ceil_ext) ? ceil_ext : shifted;
      clamp2    = (clamp1 < floor_ext) ? floor_ext : clamp1;

      speed = s3_flags_ff.loop_on ? clamp2[SPEED_W-1:0] : '0;
      if (s3_flags_ff.low_hit && speed < 0) speed = '0;
      if (s3_flags_ff.up_hit && speed > 0) speed = '0;

      if (!homed_ff || (speed >= 0 && s3_flags_ff.locked)) begin
         cmd = '0;
      end else if (speed == SPEED_MIN) begin
         cmd = SPEED_MAX;
      end else begin
         cmd = -speed;
      end

      rsp_motor_in = s3_flags_ff.tick ? cmd : motor_hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         motor_hold_ff <= '0;
      end else if (out_free) begin
         rsp_valid_ff <= s3_v_ff;
         if (s3_v_ff && s3_flags_ff.tick) motor_hold_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_motor_ff <= rsp_motor_in;
         rsp_valve_ff <= s3_flags_ff.valve;
         rsp_lock_ff  <= s3_flags_ff.locked;
         rsp_loop_ff  <= s3_flags_ff.loop_on;
         rsp_on_ff    <= s3_on_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_command  = rsp_motor_ff;
   assign rsp_solenoid_state = rsp_valve_ff;
   assign rsp_ratchet_locked = rsp_lock_ff;
   assign rsp_loop_enabled   = rsp_loop_ff;
   assign rsp_on_target      = rsp_on_ff;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for limited_pid_lift_controller: a queue-fed driver, random
// idling on both channels, and an item-by-item predictor of the PID, homing and
// ratchet logic. Depends on lplc_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;
   import lplc_pkg::*;

   localparam int LIFT_UNLOCK = UNLOCK_TICKS_DEF;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 125;
   localparam longint SUM_HI  = (64'sd1 <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO  = -(64'sd1 <<< (SUM_W - 1));
   localparam logic signed [95:0] PROD_CAP = 96'sd1 <<< PROD_LIMIT_LOG2;

   typedef struct {
      opcode_type       op;
      logic [POS_W-1:0] raw;
      logic             low;
      logic             up;
   } lift_item_type;

   typedef struct {
      logic [SPEED_W-1:0] motor;
      logic [VALVE_W-1:0] valve;
      logic               locked;
      logic               looping;
      logic               near;
   } lift_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   opcode_type                req_opcode = OP_TICK;
   logic signed [POS_W-1:0]   req_raw_position = '0;
   logic                      req_lower_limit_pressed = 1'b0;
   logic                      req_upper_limit_pressed = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SPEED_W-1:0] rsp_motor_command;
   logic [VALVE_W-1:0]        rsp_solenoid_state;
   logic                      rsp_ratchet_locked;
   logic                      rsp_loop_enabled;
   logic                      rsp_on_target;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = REG_GAIN_P;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   limited_pid_lift_controller i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_opcode              (req_opcode),
      .req_raw_position        (req_raw_position),
      .req_lower_limit_pressed (req_lower_limit_pressed),
      .req_upper_limit_pressed (req_upper_limit_pressed),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_motor_command       (rsp_motor_command),
      .rsp_solenoid_state      (rsp_solenoid_state),
      .rsp_ratchet_locked      (rsp_ratchet_locked),
      .rsp_loop_enabled        (rsp_loop_enabled),
      .rsp_on_target           (rsp_on_target),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor copy of the registers
   logic signed [GAIN_W-1:0]  cfg_gain_p  = GAIN_P_RESET;
   logic signed [GAIN_W-1:0]  cfg_gain_i  = GAIN_I_RESET;
   logic signed [GAIN_W-1:0]  cfg_gain_d  = GAIN_D_RESET;
   logic signed [SPEED_W-1:0] cfg_ceiling = SPEED_CEILING_RESET;
   logic signed [SPEED_W-1:0] cfg_floor   = SPEED_FLOOR_RESET;
   logic [COUNT_W-1:0]        cfg_top     = TOP_POSITION_RESET;
   logic [COUNT_W-1:0]        cfg_buddy   = BUDDY_POSITION_RESET;
   logic                      cfg_homed   = HOMED_RESET;

   // predictor copy of the controller state
   int                 target_pos;
   logic [POS_W-1:0]   home_offset;
   longint             err_total;
   longint             last_err;
   logic               loop_active;
   logic               ratchet_held;
   logic [TIMER_W-1:0] unlock_count;
   logic               unlock_running;
   logic [VALVE_W-1:0] valve_drive;
   logic [SPEED_W-1:0] held_drive;

   lift_item_type   pending_items[$];
   lift_status_type awaited_status[$];

   int  failures = 0;
   int  checked = 0;
   int  ticks_seen = 0;
   int  drive_ticks = 0;
   int  commands_seen = 0;
   int  homings = 0;
   bit  calm = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  recv_stall = 0;
   int  shaft_pos = 0;

   function automatic int shaft_reading(logic [POS_W-1:0] raw);
      logic [POS_W-1:0] diff;
      diff = raw - home_offset;
      return int'($signed(diff));
   endfunction

   function automatic longint clip_product(longint a, logic signed [GAIN_W-1:0] b);
      logic signed [95:0] p;
      p = a * b;
      if (p > PROD_CAP) p = PROD_CAP;
      if (p < -PROD_CAP) p = -PROD_CAP;
      return longint'(p);
   endfunction

   function automatic lift_status_type step_lift(lift_item_type it);
      lift_status_type st;
      int reading;
      int pos;
      int speed;
      int cmd;
      longint err;
      longint acc;
      longint out;
      reading = shaft_reading(it.raw);
      case (it.op)
         OP_TICK: begin
            ticks_seen++;
            if (unlock_running) begin
               if (unlock_count < 5'd31) unlock_count = unlock_count + 1'b1;
               if (unlock_count >= LIFT_UNLOCK) ratchet_held = 1'b0;
            end
            pos = reading;
            if (it.low && target_pos < pos) begin
               home_offset = it.raw;
               target_pos = 0;
               pos = 0;
               homings++;
            end
            if (it.up && target_pos > pos) begin
               home_offset = it.raw - {1'b0, cfg_top};
               target_pos = int'(cfg_top);
               homings++;
            end
            // error uses the reading from before any re-homing
            err = longint'(reading) - longint'(target_pos);
            acc = err_total + err;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            err_total = acc;
            out = clip_product(err, cfg_gain_p) + clip_product(acc, cfg_gain_i)
                  + clip_product(err - last_err, cfg_gain_d);
            out = out >>> OUT_SHIFT;
            if (out > longint'(cfg_ceiling)) out = longint'(cfg_ceiling);
            if (out < longint'(cfg_floor)) out = longint'(cfg_floor);
            last_err = err;
            speed = loop_active ? int'(out) : 0;
            if (it.low && speed < 0) speed = 0;
            if (it.up && speed > 0) speed = 0;
            if (!cfg_homed || (speed >= 0 && ratchet_held))
               cmd = 0;
            else
               cmd = -speed;
            if (cmd > 32767) cmd = 32767;
            held_drive = cmd[SPEED_W-1:0];
            if (cmd != 0) drive_ticks++;
         end
         OP_TARGET_TOP: target_pos = int'(cfg_top);
         OP_TARGET_ZERO: target_pos = 0;
         OP_TARGET_BUDDY: begin
            if (reading > int'(cfg_buddy)) target_pos = int'(cfg_buddy);
         end
         OP_LOOP_ON: loop_active = 1'b1;
         OP_LOOP_OFF: loop_active = 1'b0;
         OP_LOCK: begin
            unlock_running = 1'b0;
            unlock_count = '0;
            ratchet_held = 1'b1;
            valve_drive = VALVE_LOCK;
         end
         default: begin
            unlock_count = '0;
            unlock_running = 1'b1;
            valve_drive = VALVE_RELEASE;
         end
      endcase
      if (it.op != OP_TICK) commands_seen++;
      pos = shaft_reading(it.raw);
      st.motor = held_drive;
      st.valve = valve_drive;
      st.locked = ratchet_held;
      st.looping = loop_active;
      st.near = (pos < target_pos + AT_TARGET_BAND) && (pos > target_pos - AT_TARGET_BAND);
      return st;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // input driver
   always @(negedge clock) begin
      lift_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_opcode <= it.op;
            req_raw_position <= it.raw;
            req_lower_limit_pressed <= it.low;
            req_upper_limit_pressed <= it.up;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // result-side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         recv_stall = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: register writes, accepted items and results
   always @(posedge clock) begin
      lift_status_type want;
      lift_item_type it;
      if (reset) begin
         target_pos = 0;
         home_offset = '0;
         err_total = 0;
         last_err = 0;
         loop_active = 1'b0;
         ratchet_held = 1'b0;
         unlock_count = '0;
         unlock_running = 1'b0;
         valve_drive = VALVE_IDLE;
         held_drive = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_status.size() == 0) begin
               failures++;
               $display("%0t: result with no item outstanding, motor %0h", $time,
                        rsp_motor_command);
            end else begin
               want = awaited_status.pop_front();
               checked++;
               compare_field("motor_command", want.motor, $unsigned(rsp_motor_command));
               compare_field("solenoid_state", want.valve, rsp_solenoid_state);
               compare_field("ratchet_locked", want.locked, rsp_ratchet_locked);
               compare_field("loop_enabled", want.looping, rsp_loop_enabled);
               compare_field("on_target", want.near, rsp_on_target);
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_GAIN_P:         cfg_gain_p = csr_wdata;
               REG_GAIN_I:         cfg_gain_i = csr_wdata;
               REG_GAIN_D:         cfg_gain_d = csr_wdata;
               REG_SPEED_CEILING:  cfg_ceiling = csr_wdata[SPEED_W-1:0];
               REG_SPEED_FLOOR:    cfg_floor = csr_wdata[SPEED_W-1:0];
               REG_TOP_POSITION:   cfg_top = csr_wdata[COUNT_W-1:0];
               REG_BUDDY_POSITION: cfg_buddy = csr_wdata[COUNT_W-1:0];
               default:            cfg_homed = csr_wdata[0];
            endcase
         end
         if (req_valid && req_ready) begin
            it.op = req_opcode;
            it.raw = req_raw_position;
            it.low = req_lower_limit_pressed;
            it.up = req_upper_limit_pressed;
            awaited_status.push_back(step_lift(it));
            req_taken = 1'b1;
         end
      end
   end

   task automatic queue_item(opcode_type op, logic [POS_W-1:0] raw, logic low, logic up);
      lift_item_type it;
      it.op = op;
      it.raw = raw;
      it.low = low;
      it.up = up;
      pending_items.push_back(it);
   endtask

   // mostly ticks from a lift wandering along the shaft, with commands mixed in
   task automatic queue_random_item();
      int pick;
      logic [POS_W-1:0] raw;
      opcode_type op;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         shaft_pos = int'($urandom_range(0, 400000)) - 200000;
      else
         shaft_pos += int'($urandom_range(0, 4000)) - 2000;
      raw = ($urandom_range(0, 19) == 0) ? POS_W'($urandom) : shaft_pos[POS_W-1:0];
      op = ($urandom_range(0, 99) < 68) ? OP_TICK : opcode_type'($urandom_range(1, 7));
      queue_item(op, raw, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || awaited_status.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_settings(int kind);
      logic [CSR_DATA_W-1:0] v [8];
      v[0] = 32'(-int'($urandom_range(2000, 40000)));
      v[1] = 32'(-int'($urandom_range(0, 60)));
      v[2] = 32'(-int'($urandom_range(0, 200000)));
      v[3] = 32'($urandom_range(8000, 32767));
      v[4] = 32'(-int'($urandom_range(8000, 32768)));
      v[5] = 32'($urandom_range(0, 200000));
      v[6] = 32'($urandom_range(0, 200000));
      v[7] = 32'd1;
      case (kind)
         2: begin
            v[0] = 32'h7FFF_FFFF;
            v[1] = 32'h8000_0000;
            v[2] = 32'h7FFF_FFFF;
            v[3] = 32'h0000_7FFF;
            v[4] = 32'hFFFF_8000;
            v[5] = 32'h007F_FFFF;
            v[6] = 32'd0;
         end
         3: begin
            // floor above ceiling
            v[0] = 32'h8000_0000;
            v[1] = 32'h7FFF_FFFF;
            v[2] = 32'h8000_0000;
            v[3] = 32'(-1000);
            v[4] = 32'd1000;
            v[6] = 32'h007F_FFFF;
         end
         4: v[7] = 32'd0;
         5: begin
            v[0] = $urandom;
            v[1] = $urandom;
            v[2] = $urandom;
            v[3] = $urandom;
            v[4] = $urandom;
            v[5] = $urandom;
            v[6] = $urandom;
            v[7] = $urandom;
         end
         6: begin
            v[0] = 32'(GAIN_P_RESET);
            v[1] = 32'(GAIN_I_RESET);
            v[2] = 32'(GAIN_D_RESET);
            v[3] = 32'(SPEED_CEILING_RESET);
            v[4] = 32'(SPEED_FLOOR_RESET);
            v[5] = 32'(TOP_POSITION_RESET);
            v[6] = 32'(BUDDY_POSITION_RESET);
            v[7] = 32'(HOMED_RESET);
         end
         default: ;
      endcase
      csr_write(REG_GAIN_P, v[0]);
      csr_write(REG_GAIN_I, v[1]);
      csr_write(REG_GAIN_D, v[2]);
      csr_write(REG_SPEED_CEILING, v[3]);
      csr_write(REG_SPEED_FLOOR, v[4]);
      csr_write(REG_TOP_POSITION, v[5]);
      csr_write(REG_BUDDY_POSITION, v[6]);
      csr_write(REG_HOMED_AT_START, v[7]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, every opcode, limits and position extremes
      queue_item(OP_TICK, 24'h000000, 1'b0, 1'b0);
      queue_item(OP_LOOP_ON, 24'h000000, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h000100, 1'b1, 1'b0);
      queue_item(OP_TICK, 24'h7FFFFF, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h800000, 1'b1, 1'b0);
      queue_item(OP_TARGET_BUDDY, 24'h801000, 1'b0, 1'b0);
      queue_item(OP_TARGET_BUDDY, 24'h800010, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h000000, 1'b0, 1'b1);
      queue_item(OP_TARGET_TOP, 24'hFFFFFF, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h801F40, 1'b0, 1'b0);
      queue_item(OP_TARGET_ZERO, 24'hFFFFFF, 1'b1, 1'b1);
      queue_item(OP_LOCK, 24'h555555, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h810000, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h7F0000, 1'b0, 1'b0);
      queue_item(OP_RELEASE, 24'hAAAAAA, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h7F0000, 1'b1, 1'b1);
      queue_item(OP_LOOP_OFF, 24'h123456, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h123456, 1'b0, 1'b0);
      queue_item(OP_LOOP_ON, 24'h000000, 1'b0, 1'b0);
      queue_item(OP_TICK, 24'h7FFFFF, 1'b1, 1'b1);
      queue_item(OP_TICK, 24'h000000, 1'b0, 1'b1);
      drain();

      for (int phase = 1; phase <= PHASES; phase++) begin
         load_settings(phase);
         if (phase == PHASES) calm = 1'b1;
         // home at the bottom and close the loop before the random mix
         shaft_pos = int'($urandom_range(0, 20000));
         queue_item(OP_LOOP_ON, shaft_pos[POS_W-1:0], 1'b0, 1'b0);
         queue_item(OP_TICK, shaft_pos[POS_W-1:0], 1'b1, 1'b0);
         queue_item(OP_TARGET_BUDDY, shaft_pos[POS_W-1:0], 1'b0, 1'b0);
         repeat (PHASE_ITEMS) queue_random_item();
         drain();
      end

      repeat (20) @(posedge clock);
      $display("checked %0d results: %0d ticks (%0d driving), %0d commands, %0d homing events",
               checked, ticks_seen, drive_ticks, commands_seen, homings);
      $display("register settings: reset, typical, extreme, inverted window, unhomed, random");
      if (failures == 0 && awaited_status.size() == 0) begin
         $display("limited_pid_lift_controller regression: pass");
      end else begin
         $display("limited_pid_lift_controller regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", awaited_status.size());
      $display("limited_pid_lift_controller regression: fail");
      $finish;
   end

endmodule

@@ limited_pid_lift_controller.f @@
sv/lplc_pkg.sv
sv/limited_pid_lift_controller.sv
bench/testbench.sv
